// ----- design/sac_pkg.sv -----
package sac_pkg;

    localparam int CACHE_BYTES_DEF = 16384;
    localparam int LINE_BYTES_DEF  = 32;
    localparam int ADDR_BITS_DEF   = 32;

    localparam logic CFG_WAYS   = 1'b0;
    localparam logic CFG_POLICY = 1'b1;

    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_NO_WA    = 2'd1;
    localparam logic [1:0] MODE_PF_ALL   = 2'd2;
    localparam logic [1:0] MODE_PF_MISS  = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [31:0] address;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic        prefetch_filled;
        logic [31:0] hit_count;
    } t_rsp;

    typedef struct packed {
        logic start;
        logic sel_next;
        logic upd;
    } t_cmd;

    typedef struct packed {
        logic do_pref;
    } t_sts;

endpackage

// ----- design/sac_ctrl.sv -----
module sac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    input  sac_pkg::t_sts i_sts,
    output sac_pkg::t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_UPD  = 6'b000100,
        S_PRD  = 6'b001000,
        S_PUPD = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_req_stall  = 1'b1;
        o_rsp_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_stall = 1'b0;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.do_pref ? S_PRD : S_OUT;
            end
            S_PRD: begin
                o_cmd.sel_next = 1'b1;
                n_state        = S_PUPD;
            end
            S_PUPD: begin
                o_cmd.sel_next = 1'b1;
                o_cmd.upd      = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_rsp_valid = 1'b1;
                if (!i_rsp_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/sac_dp.sv -----
module sac_dp #(
    parameter int CACHE_BYTES = sac_pkg::CACHE_BYTES_DEF,
    parameter int LINE_BYTES  = sac_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS   = sac_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sac_pkg::t_cmd i_cmd,
    output sac_pkg::t_sts o_sts,
    input  sac_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [2:0]    i_cfg_data,
    output sac_pkg::t_rsp o_rsp
);

    localparam int NLINES    = CACHE_BYTES / LINE_BYTES;
    localparam int LINE_LOG2 = $clog2(LINE_BYTES);
    localparam int BLK       = ADDR_BITS - LINE_LOG2;
    localparam int ROW       = (NLINES < 16) ? NLINES : 16;
    localparam int LW        = $clog2(ROW);
    localparam int NROWS     = NLINES / ROW;
    localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1;
    localparam int NLL       = $clog2(NLINES);

    sac_pkg::t_req r_req;
    logic [2:0]    r_wl;
    logic [1:0]    r_mode;
    logic [31:0]   r_hits;
    logic          r_hit;
    logic          r_pf;
    logic [NROWS-1:0] r_rowv;

    logic [ROW-1:0][BLK-1:0] m_tag  [NROWS];
    logic [ROW-1:0]          m_val  [NROWS];
    logic [ROW-1:0][LW-1:0]  m_rank [NROWS];

    logic [ROW-1:0][BLK-1:0] r_rd_tag;
    logic [ROW-1:0]          r_rd_val;
    logic [ROW-1:0][LW-1:0]  r_rd_rank;

    logic [2:0]           wl;
    logic [LW:0]          wfull;
    logic [LW-1:0]        wmask;
    logic [ADDR_BITS-1:0] addr_e;
    logic [BLK-1:0]       blk;
    logic [BLK-1:0]       lb;
    logic [NLL:0]         nsets;
    logic [NLL-1:0]       base;
    logic [RW-1:0]        rowi;
    logic [LW-1:0]        off;
    logic                 rowv;

    logic [ROW-1:0]          lv;
    logic [ROW-1:0][LW-1:0]  lr;
    logic [ROW-1:0]          ins;
    logic [ROW-1:0]          mt;
    logic                    hit;
    logic [LW-1:0]           hl;
    logic [LW-1:0]           vl;
    logic [LW-1:0]           tl;
    logic                    hfound;
    logic                    vfound;
    logic [LW-1:0]           rt;
    logic                    alloc;
    logic                    fill;
    logic                    we;
    logic [ROW-1:0][BLK-1:0] nt;
    logic [ROW-1:0]          nv;
    logic [ROW-1:0][LW-1:0]  nr;

    always_comb begin
        wl     = (r_wl > 3'(LW)) ? 3'(LW) : r_wl;
        wfull  = (LW+1)'(1) << wl;
        wmask  = LW'(wfull - 1'b1);
        addr_e = ADDR_BITS'(r_req.address);
        blk    = addr_e[ADDR_BITS-1:LINE_LOG2];
        lb     = i_cmd.sel_next ? blk + 1'b1 : blk;
        nsets  = (NLL+1)'(NLINES) >> wl;
        base   = (NLL'(lb) & NLL'(nsets - 1'b1)) << wl;
        rowi   = RW'(base >> LW);
        off    = LW'(base);
        rowv   = r_rowv[rowi];
    end

    always_comb begin
        hl     = off;
        vl     = off;
        hfound = 1'b0;
        vfound = 1'b0;
        for (int l = 0; l < ROW; l++) begin
            lv[l]  = rowv & r_rd_val[l];
            lr[l]  = rowv ? r_rd_rank[l] : (LW'(l) & wmask);
            ins[l] = ((LW'(l) ^ off) & ~wmask) == '0;
            mt[l]  = ins[l] & lv[l] & (r_rd_tag[l] == lb);
            if (!hfound && mt[l]) begin
                hl     = LW'(l);
                hfound = 1'b1;
            end
            if (!vfound && ins[l] && lr[l] == '0) begin
                vl     = LW'(l);
                vfound = 1'b1;
            end
        end
        hit   = |mt;
        tl    = hit ? hl : vl;
        rt    = lr[tl];
        alloc = i_cmd.sel_next
              | !(r_mode == sac_pkg::MODE_NO_WA && r_req.req_type);
        fill  = !hit & alloc;
        we    = i_cmd.upd & (hit | alloc);
        for (int l = 0; l < ROW; l++) begin
            nt[l] = r_rd_tag[l];
            nv[l] = lv[l];
            nr[l] = lr[l];
            if (ins[l] && lr[l] > rt) begin
                nr[l] = lr[l] - 1'b1;
            end
            if (LW'(l) == tl) begin
                nr[l] = wmask;
                if (fill) begin
                    nt[l] = lb;
                    nv[l] = 1'b1;
                end
            end
        end
        o_sts.do_pref = (r_mode == sac_pkg::MODE_PF_ALL)
                      | (r_mode == sac_pkg::MODE_PF_MISS && !hit);
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag  <= m_tag[rowi];
        r_rd_val  <= m_val[rowi];
        r_rd_rank <= m_rank[rowi];
        if (we) begin
            m_tag[rowi]  <= nt;
            m_val[rowi]  <= nv;
            m_rank[rowi] <= nr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_req;
            r_pf  <= 1'b0;
        end
        if (i_cmd.upd && !i_cmd.sel_next) begin
            r_hit <= hit;
        end
        if (i_cmd.upd && i_cmd.sel_next) begin
            r_pf <= fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl   <= 3'd1;
            r_mode <= sac_pkg::MODE_ALLOC;
            r_hits <= '0;
            r_rowv <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sac_pkg::CFG_WAYS: begin
                        r_wl   <= i_cfg_data;
                        r_rowv <= '0;
                    end
                    sac_pkg::CFG_POLICY: begin
                        r_mode <= i_cfg_data[1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (we) begin
                r_rowv[rowi] <= 1'b1;
            end
            if (i_cmd.upd && !i_cmd.sel_next && hit && r_hits != '1) begin
                r_hits <= r_hits + 1'b1;
            end
        end
    end

    assign o_rsp.hit             = r_hit;
    assign o_rsp.prefetch_filled = r_pf;
    assign o_rsp.hit_count       = r_hits;

endmodule

// ----- design/set_assoc_lru_cache_with_prefetch_unit.sv -----
// Flow: accept, registered row read of the tag store, then a write-back
// (none for a write miss in no-write-allocate mode); with a prefetch the next
// line's row is read and written back too. No new request until result accept.
// Reset: synchronous, active low; clears control, config and hit count.
// Per-row valid flops clear the tag store at once; no clearing pass.
module set_assoc_lru_cache_with_prefetch_unit #(
    parameter int CACHE_BYTES = sac_pkg::CACHE_BYTES_DEF,
    parameter int LINE_BYTES  = sac_pkg::LINE_BYTES_DEF,
    parameter int ADDR_BITS   = sac_pkg::ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  sac_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output sac_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [2:0]    i_cfg_data
);

    sac_pkg::t_cmd cmd;
    sac_pkg::t_sts sts;

    sac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sac_dp #(
        .CACHE_BYTES (CACHE_BYTES),
        .LINE_BYTES  (LINE_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (o_rsp)
    );

    a_rsp_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_req_stall)
        else $error("request taken while result pending");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> (o_req_stall && !o_rsp_valid))
        else $error("request not held busy after accept");

    a_rsp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_stall) |=> !o_rsp_valid)
        else $error("result repeated");

endmodule
